>>> rtl/core/timer_expiry_queue_defines.svh
// Assertion macros for the timer expiry queue checkers.
// Expects clk and rst_n in the scope of use.
`ifndef TIMER_EXPIRY_QUEUE_DEFINES_SVH
`define TIMER_EXPIRY_QUEUE_DEFINES_SVH

`define TEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define TEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/teq_pkg.sv
// Shared types and constants of the timer expiry queue.
// No dependencies.
package teq_pkg;
  localparam int ENTRIES     = 16;
  localparam int IDX_BITS    = $clog2(ENTRIES);
  localparam int TIME_BITS   = 48;
  localparam int TAG_BITS    = 16;
  localparam int PERIOD_BITS = 32;
  localparam int SLOT_BITS   = 4;
  localparam int KIND_BITS   = 3;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_t;

  typedef enum logic [KIND_BITS-1:0] {
    K_ADDED    = 3'd0,
    K_FULL     = 3'd1,
    K_CANCELED = 3'd2,
    K_MISS     = 3'd3,
    K_EXPIRED  = 3'd4,
    K_SUMMARY  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [TIME_BITS-1:0]   expire_at;
    logic [PERIOD_BITS-1:0] period;
    logic [SLOT_BITS-1:0]   cancel_slot;
    logic [TAG_BITS-1:0]    cancel_tag;
    logic [TIME_BITS-1:0]   now_time;
  } in_beat_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [SLOT_BITS-1:0] slot;
    logic [TAG_BITS-1:0]  tag;
    logic                 head_moved;
    logic [TIME_BITS-1:0] next_due;
    logic                 next_valid;
    logic                 last;
  } out_beat_t;

  // token passed cell to cell during a minimum search
  typedef struct packed {
    logic                 active;
    logic                 use_due;
    logic                 any;
    logic [TIME_BITS-1:0] best;
    logic [IDX_BITS-1:0]  idx;
    logic [TAG_BITS-1:0]  tag;
  } carry_t;

  // command broadcast from the controller to all cells
  typedef struct packed {
    logic                   wr_en;
    logic                   cancel_en;
    logic                   snap_en;
    logic                   pick_en;
    logic [IDX_BITS-1:0]    idx;
    logic [TAG_BITS-1:0]    tag;
    logic [TIME_BITS-1:0]   expiry;
    logic [PERIOD_BITS-1:0] period;
    logic [TIME_BITS-1:0]   now;
  } cmd_t;
endpackage

>>> rtl/core/teq_if.sv
// Valid/ready channel interfaces of the timer expiry queue.
// Depends on teq_pkg.
interface teq_in_if;
  logic              valid;
  logic              ready;
  teq_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface teq_out_if;
  logic               valid;
  logic               ready;
  teq_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/timer_expiry_queue.sv
// Timer expiry queue: a row of ENTRIES slot cells and a controller.
// Each minimum search runs one token down the cell row.
// Add and cancel: one search, then one result beat.
// Tick with n expired timers: n + 2 searches, then n + 1 result beats.
// One item at a time; in_bus.ready is high only when idle.
// Synchronous active-low reset clears all slots and the tag counter.
module timer_expiry_queue (
  input  logic clk,
  input  logic rst_n,
  teq_in_if.sink    in_bus,
  teq_out_if.source out_bus
);
  import teq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LAUNCH, S_QUERY, S_EMIT, S_WAIT
  } state_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    logic [TAG_BITS-1:0] tag;
  } pick_t;

  state_t                 state_r;
  logic [1:0]             op_r;
  logic [TIME_BITS-1:0]   exp_r;
  logic [PERIOD_BITS-1:0] per_r;
  logic [SLOT_BITS-1:0]   cslot_r;
  logic [TAG_BITS-1:0]    ctag_r;
  logic                   inrange_r;
  logic [TAG_BITS-1:0]    tag_cnt_r;
  logic                   final_r;
  logic                   launch_r, use_due_r;
  cmd_t                   cmd_r;
  pick_t                  q_r [ENTRIES];
  logic [IDX_BITS:0]      q_cnt_r, rd_r;
  logic [TIME_BITS-1:0]   fin_next_r;
  logic                   fin_nv_r;
  out_beat_t              out_r;
  logic                   out_valid_r;

  carry_t                 chain [ENTRIES+1];
  logic [ENTRIES-1:0]     valid_v, hit_v;
  carry_t                 tail;
  logic                   in_fire, out_fire, full, chg;
  logic [IDX_BITS-1:0]    free_idx;
  logic [TIME_BITS-1:0]   tail_next;

  assign chain[0] = '{active: launch_r, use_due: use_due_r, any: 1'b0,
                      best: '0, idx: '0, tag: '0};

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    teq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_BITS'(g)),
      .cmd       (cmd_r),
      .carry_in  (chain[g]),
      .carry_out (chain[g+1]),
      .valid     (valid_v[g]),
      .hit       (hit_v[g])
    );
  end

  assign tail = chain[ENTRIES];

  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_v[i]) free_idx = IDX_BITS'(i);
    end
  end

  assign full      = &valid_v;
  assign tail_next = tail.any ? tail.best : '0;
  assign chg       = !tail.any || (exp_r < tail.best);
  assign in_fire   = in_bus.valid && in_bus.ready;
  assign out_fire  = out_valid_r && out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tag_cnt_r   <= '0;
      launch_r    <= 1'b0;
      use_due_r   <= 1'b0;
      out_valid_r <= 1'b0;
      final_r     <= 1'b0;
      q_cnt_r     <= '0;
      rd_r        <= '0;
      cmd_r.wr_en     <= 1'b0;
      cmd_r.cancel_en <= 1'b0;
      cmd_r.snap_en   <= 1'b0;
      cmd_r.pick_en   <= 1'b0;
    end else begin
      launch_r        <= 1'b0;
      cmd_r.wr_en     <= 1'b0;
      cmd_r.cancel_en <= 1'b0;
      cmd_r.snap_en   <= 1'b0;
      cmd_r.pick_en   <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r      <= in_bus.data.opcode;
            exp_r     <= in_bus.data.expire_at;
            per_r     <= in_bus.data.period;
            cslot_r   <= in_bus.data.cancel_slot;
            ctag_r    <= in_bus.data.cancel_tag;
            inrange_r <= int'(in_bus.data.cancel_slot) < ENTRIES;
            final_r   <= 1'b0;
            q_cnt_r   <= '0;
            cmd_r.idx <= IDX_BITS'(in_bus.data.cancel_slot);
            cmd_r.tag <= in_bus.data.cancel_tag;
            cmd_r.now <= in_bus.data.now_time;
            unique case (in_bus.data.opcode)
              OP_ADD: state_r <= S_LAUNCH;
              OP_CANCEL: begin
                cmd_r.cancel_en <= int'(in_bus.data.cancel_slot) < ENTRIES;
                state_r         <= S_LAUNCH;
              end
              OP_TICK: begin
                cmd_r.snap_en <= 1'b1;
                state_r       <= S_LAUNCH;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_LAUNCH: begin
          launch_r  <= 1'b1;
          use_due_r <= (op_r == OP_TICK) && !final_r;
          state_r   <= S_QUERY;
        end
        S_QUERY: begin
          if (tail.active) begin
            unique case (op_r)
              OP_ADD: begin
                out_valid_r <= 1'b1;
                if (full) begin
                  out_r <= '{kind: K_FULL, slot: '0, tag: '0, head_moved: 1'b0,
                             next_due: tail_next, next_valid: tail.any,
                             last: 1'b1};
                end else begin
                  cmd_r.wr_en  <= 1'b1;
                  cmd_r.idx    <= free_idx;
                  cmd_r.tag    <= tag_cnt_r;
                  cmd_r.expiry <= exp_r;
                  cmd_r.period <= per_r;
                  tag_cnt_r    <= tag_cnt_r + 1'b1;
                  out_r <= '{kind: K_ADDED, slot: SLOT_BITS'(free_idx), tag: tag_cnt_r,
                             head_moved: chg,
                             next_due: chg ? exp_r : tail.best,
                             next_valid: 1'b1, last: 1'b1};
                end
                state_r <= S_WAIT;
              end
              OP_CANCEL: begin
                out_valid_r <= 1'b1;
                out_r <= '{kind: (inrange_r && |hit_v) ? K_CANCELED : K_MISS,
                           slot: cslot_r, tag: ctag_r, head_moved: 1'b0,
                           next_due: tail_next, next_valid: tail.any, last: 1'b1};
                state_r <= S_WAIT;
              end
              default: begin
                if (final_r) begin
                  fin_next_r <= tail_next;
                  fin_nv_r   <= tail.any;
                  rd_r       <= '0;
                  state_r    <= S_EMIT;
                end else if (tail.any) begin
                  q_r[q_cnt_r[IDX_BITS-1:0]] <= '{idx: tail.idx, tag: tail.tag};
                  q_cnt_r       <= q_cnt_r + 1'b1;
                  cmd_r.pick_en <= 1'b1;
                  cmd_r.idx     <= tail.idx;
                  state_r       <= S_LAUNCH;
                end else begin
                  final_r <= 1'b1;
                  state_r <= S_LAUNCH;
                end
              end
            endcase
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_fire) begin
            out_valid_r <= 1'b1;
            if (rd_r < q_cnt_r) begin
              out_r <= '{kind: K_EXPIRED, slot: SLOT_BITS'(q_r[rd_r[IDX_BITS-1:0]].idx),
                         tag: q_r[rd_r[IDX_BITS-1:0]].tag, head_moved: 1'b0,
                         next_due: fin_next_r, next_valid: fin_nv_r, last: 1'b0};
              rd_r <= rd_r + 1'b1;
            end else begin
              out_r <= '{kind: K_SUMMARY, slot: '0, tag: '0, head_moved: 1'b0,
                         next_due: fin_next_r, next_valid: fin_nv_r, last: 1'b1};
              state_r <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (out_fire) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_bus.ready  = (state_r == S_IDLE);
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_r;
endmodule

>>> rtl/core/teq_cell.sv
// One timer slot: stored timer, due flag and one stage of the minimum search.
// Depends on teq_pkg.
module teq_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [teq_pkg::IDX_BITS-1:0]  cell_idx,
  input  teq_pkg::cmd_t                 cmd,
  input  teq_pkg::carry_t               carry_in,
  output teq_pkg::carry_t               carry_out,
  output logic                          valid,
  output logic                          hit
);
  import teq_pkg::*;

  logic                   valid_r, due_r, hit_r;
  logic [TIME_BITS-1:0]   exp_r;
  logic [PERIOD_BITS-1:0] per_r;
  logic [TAG_BITS-1:0]    tag_r;
  carry_t                 carry_r, carry_nxt;
  logic                   mine, match, cand;
  logic [TIME_BITS-1:0]   per_ext, room, restart;

  assign mine    = (cmd.idx == cell_idx);
  assign match   = valid_r && mine && (tag_r == cmd.tag);
  assign per_ext = TIME_BITS'(per_r);
  assign room    = TIME_MAX - cmd.now;
  assign restart = (per_ext > room) ? TIME_MAX : cmd.now + per_ext;
  assign cand    = carry_in.use_due ? due_r : valid_r;

  always_comb begin
    carry_nxt = carry_in;
    if (carry_in.active && cand && (!carry_in.any || exp_r < carry_in.best)) begin
      carry_nxt.any  = 1'b1;
      carry_nxt.best = exp_r;
      carry_nxt.idx  = cell_idx;
      carry_nxt.tag  = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r        <= 1'b0;
      due_r          <= 1'b0;
      hit_r          <= 1'b0;
      carry_r.active <= 1'b0;
    end else begin
      carry_r <= carry_nxt;
      if (cmd.wr_en && mine) valid_r <= 1'b1;
      if (cmd.cancel_en) begin
        hit_r <= match;
        if (match) valid_r <= 1'b0;
      end
      if (cmd.snap_en) due_r <= valid_r && (exp_r <= cmd.now);
      if (cmd.pick_en && mine) begin
        due_r <= 1'b0;
        if (per_r == '0) valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && mine) begin
      exp_r <= cmd.expiry;
      per_r <= cmd.period;
      tag_r <= cmd.tag;
    end else if (cmd.pick_en && mine && per_r != '0) begin
      exp_r <= restart;
    end
  end

  assign carry_out = carry_r;
  assign valid     = valid_r;
  assign hit       = hit_r;
endmodule

>>> rtl/core/teq_checker.sv
// Port-level checks of the timer expiry queue, bound to the top level.
// Depends on teq_pkg and timer_expiry_queue_defines.svh.
`include "timer_expiry_queue_defines.svh"

module teq_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [1:0]           in_opcode,
  input logic                 out_valid,
  input logic                 out_ready,
  input teq_pkg::out_beat_t   out_data
);
  import teq_pkg::*;

  `TEQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_data), "result beat changed while stalled")
  `TEQ_ASSERT_NEXT(a_busy, in_valid && in_ready && in_opcode != OP_RSVD, !in_ready,
                   "accepted a beat while busy")
  `TEQ_ASSERT_NOW(a_last, out_valid && out_data.kind != K_EXPIRED, out_data.last,
                  "closing beat without last")
  `TEQ_ASSERT_NOW(a_full, out_valid && out_data.kind == K_FULL, out_data.next_valid,
                  "full table reported empty")
endmodule

bind timer_expiry_queue teq_checker u_teq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_opcode (in_bus.data.opcode),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_data  (out_bus.data)
);

>>> verif/timer_expiry_queue_tb.sv
// Self-checking testbench of the timer expiry queue: adds, cancels and ticks
// against a timer table predictor, scoreboard class checks every result beat.
// Depends on teq_pkg, teq_if and the timer_expiry_queue RTL.
module timer_expiry_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import teq_pkg::*;

  class timer_board;
    bit                     live [ENTRIES];
    logic [TIME_BITS-1:0]   due_at [ENTRIES];
    logic [PERIOD_BITS-1:0] every [ENTRIES];
    logic [TAG_BITS-1:0]    seq [ENTRIES];
    logic [TAG_BITS-1:0]    next_seq;
    out_beat_t              pending [$];
    int                     errors;

    function void clear();
      foreach (live[i]) live[i] = 0;
      next_seq = '0;
      pending.delete();
      errors = 0;
    endfunction

    function bit earliest(output logic [TIME_BITS-1:0] when);
      bit any;
      any = 0;
      when = '0;
      for (int i = 0; i < ENTRIES; i++)
        if (live[i] && (!any || due_at[i] < when)) begin
          when = due_at[i];
          any = 1;
        end
      return any;
    endfunction

    function void note_item(in_beat_t b);
      out_beat_t r [$];
      logic [TIME_BITS-1:0] prev, nx;
      bit any, hit [ENTRIES];
      int fs, pick;
      int order [$];
      out_beat_t o;
      o = '0;
      if (b.opcode == OP_ADD) begin
        any = earliest(prev);
        fs = -1;
        for (int i = ENTRIES - 1; i >= 0; i--) if (!live[i]) fs = i;
        o.last = 1;
        if (fs < 0) o.kind = K_FULL;
        else begin
          o.kind = K_ADDED;
          o.slot = SLOT_BITS'(fs);
          o.tag = next_seq;
          o.head_moved = !any || b.expire_at < prev;
          live[fs] = 1;
          due_at[fs] = b.expire_at;
          every[fs] = b.period;
          seq[fs] = next_seq;
          next_seq++;
        end
        r.push_back(o);
      end else if (b.opcode == OP_CANCEL) begin
        o.slot = b.cancel_slot;
        o.tag = b.cancel_tag;
        o.last = 1;
        if (live[b.cancel_slot] && seq[b.cancel_slot] == b.cancel_tag) begin
          live[b.cancel_slot] = 0;
          o.kind = K_CANCELED;
        end else o.kind = K_MISS;
        r.push_back(o);
      end else if (b.opcode == OP_TICK) begin
        for (int i = 0; i < ENTRIES; i++) hit[i] = live[i] && due_at[i] <= b.now_time;
        forever begin
          pick = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (hit[i] && (pick < 0 || due_at[i] < due_at[pick])) pick = i;
          if (pick < 0) break;
          hit[pick] = 0;
          order.push_back(pick);
        end
        foreach (order[k]) begin
          if (every[order[k]] != 0) begin
            if (TIME_BITS'(every[order[k]]) > TIME_MAX - b.now_time)
              due_at[order[k]] = TIME_MAX;
            else due_at[order[k]] = b.now_time + every[order[k]];
          end else live[order[k]] = 0;
        end
        foreach (order[k]) begin
          o = '0;
          o.kind = K_EXPIRED;
          o.slot = SLOT_BITS'(order[k]);
          o.tag = seq[order[k]];
          r.push_back(o);
        end
        o = '0;
        o.kind = K_SUMMARY;
        o.last = 1;
        r.push_back(o);
      end
      any = earliest(nx);
      foreach (r[k]) begin
        r[k].next_due = nx;
        r[k].next_valid = any;
        pending.push_back(r[k]);
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t exp_b;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $realtime, got);
        errors++;
        return;
      end
      exp_b = pending.pop_front();
      if (got !== exp_b) begin
        $display("%0t: mismatch, expected %h actual %h", $realtime, exp_b, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  teq_in_if  in_bus ();
  teq_out_if out_bus ();
  timer_board board;
  int send_idle, recv_idle;

  timer_expiry_queue i_dut (.clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus));

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) board.check_result(out_bus.data);
    out_bus.ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99) < send_idle) begin
      in_bus.valid <= 0;
      @(posedge clk);
    end
    in_bus.valid <= 1;
    in_bus.data <= b;
    do @(posedge clk); while (!in_bus.ready);
    board.note_item(b);
  endtask

  function automatic logic [TIME_BITS-1:0] rand_time();
    case ($urandom_range(3))
      0: return TIME_BITS'({$urandom, $urandom});
      1: return TIME_MAX - TIME_BITS'($urandom_range(2000));
      default: return TIME_BITS'(1000 + $urandom_range(4000));
    endcase
  endfunction

  task automatic drive_random(int n);
    in_beat_t b;
    int s;
    repeat (n) begin
      b = in_beat_t'($bits(in_beat_t)'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          b.opcode = OP_ADD;
          b.expire_at = rand_time();
          b.period = $urandom_range(2) == 0 ? 0 :
                     ($urandom_range(4) == 0 ? $urandom : $urandom_range(3000));
        end
        4, 5: begin
          b.opcode = OP_CANCEL;
          s = $urandom_range(ENTRIES - 1);
          b.cancel_slot = SLOT_BITS'(s);
          if ($urandom_range(2) != 0 && board.live[s]) b.cancel_tag = board.seq[s];
        end
        9: b.opcode = OP_RSVD;
        default: begin
          b.opcode = OP_TICK;
          b.now_time = rand_time();
        end
      endcase
      send_beat(b);
    end
  endtask

  task automatic wait_drained();
    in_bus.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    in_beat_t b;
    board = new();
    board.clear();
    rst_n = 0;
    in_bus.valid = 0;
    in_bus.data = '0;
    send_idle = 9;
    recv_idle = 65;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    b = '0;
    b.opcode = OP_TICK;
    send_beat(b);
    for (int i = 0; i < ENTRIES + 1; i++) begin
      b = '0;
      b.opcode = OP_ADD;
      b.expire_at = i == 0 ? TIME_MAX : (i == 1 ? '0 : 48'd50 - i);
      b.period = i == 2 ? '1 : (i % 2);
      send_beat(b);
    end
    b = '0;
    b.opcode = OP_CANCEL;
    b.cancel_slot = 4'hF;
    b.cancel_tag = 16'hFFFF;
    send_beat(b);
    b.cancel_slot = 3;
    b.cancel_tag = 3;
    send_beat(b);
    b = '0;
    b.opcode = OP_TICK;
    b.now_time = TIME_MAX - 1;
    send_beat(b);
    b.now_time = TIME_MAX;
    send_beat(b);
    b = '1;
    send_beat(b);
    drive_random(120);
    wait_drained();
    send_idle = 65;
    recv_idle = 9;
    drive_random(120);
    send_idle = 0;
    recv_idle = 0;
    drive_random(120);
    wait_drained();
    if (board.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
